>>> rtl/core/polar_cartesian_converter_assert.svh
// Assertion macros used by the checker of the converter.
`ifndef POLAR_CARTESIAN_CONVERTER_ASSERT_SVH
`define POLAR_CARTESIAN_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define PCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pcc_pkg.sv
package pcc_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 24;

    // Field width on the ports.
    localparam int DW = 32;
    // CORDIC x and y width, enough for a Q16.16 length with 32 fraction bits.
    localparam int CW = 50;
    // CORDIC angle width; vectoring can start at +pi and still move.
    localparam int ZW = 34;
    // Width of a value handed to the coordinate clamp.
    localparam int SW = 40;
    // Width of a partial product of the gain correction.
    localparam int PW = 60;

    localparam logic FUNC_TO_CART  = 1'b0;
    localparam logic FUNC_TO_POLAR = 1'b1;

    // Inverse CORDIC gain as a Q0.32 fraction.
    localparam logic [DW-1:0] INV_GAIN    = 32'h9B74_EDA8;
    localparam logic [15:0]   INV_GAIN_HI = INV_GAIN[31:16];
    localparam logic [15:0]   INV_GAIN_LO = INV_GAIN[15:0];

    // atan(2^-i) in binary angle units, a full turn being 2^32.
    localparam logic [DW-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Item as it travels through the rotation stages. In cartesian mode the
    // echo words hold the clamped length and the angle; in polar mode they hold
    // the clamped components.
    typedef struct packed {
        logic                 func;
        logic                 zero;
        logic                 sat;
        logic [DW-1:0]        echo0;
        logic [DW-1:0]        echo1;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [DW-1:0] x_out;
        logic signed [DW-1:0] y_out;
        logic [DW-1:0]        magnitude_out;
        logic signed [DW-1:0] angle_out;
        logic                 saturated;
    } res_t;

    // Clamps v to the signed range of cw bits. Returns {flag, value}.
    function automatic logic [DW:0] clamp_coord(input logic signed [SW-1:0] v,
                                                input int cw);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] r;
        logic                 f;
        begin
            hi = (SW'(1) << (cw - 1)) - SW'(1);
            lo = ~hi;
            r  = v;
            f  = 1'b0;
            if (v > hi)
            begin
                r = hi;
                f = 1'b1;
            end
            if (v < lo)
            begin
                r = lo;
                f = 1'b1;
            end
            return {f, r[DW-1:0]};
        end
    endfunction

endpackage

>>> rtl/core/pcc_pre.sv
module pcc_pre #(
    parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic                           func,
    input  logic signed [pcc_pkg::DW-1:0]  magnitude_in,
    input  logic signed [pcc_pkg::DW-1:0]  angle_in,
    input  logic signed [pcc_pkg::DW-1:0]  x_coord,
    input  logic signed [pcc_pkg::DW-1:0]  y_coord,
    input  logic                           flip_x,
    input  logic                           flip_y,
    output logic                           out_valid,
    output pcc_pkg::cordic_t               out_data
);
    import pcc_pkg::*;

    localparam int CW_EFF = (COORD_WIDTH < DW) ? COORD_WIDTH : DW;
    localparam int XW     = DW + 1;
    localparam int X8W    = XW + 8;
    localparam int MW     = 2 * DW;
    localparam int XSW    = MW - 16;
    localparam logic signed [DW-1:0] QUARTER = 32'sd1073741824;

    // First stage: gain-corrected length product and the flipped components.
    logic                    a_valid_reg, a_valid_next;
    logic                    a_func_reg;
    logic signed [DW-1:0]    a_mag_reg;
    logic signed [DW-1:0]    a_ang_reg;
    logic signed [MW-1:0]    a_prod_reg, a_prod_next;
    logic signed [XW-1:0]    a_xf_reg, a_xf_next;
    logic signed [XW-1:0]    a_yf_reg, a_yf_next;
    logic signed [MW:0]      prod_full;
    logic signed [XW-1:0]    x_ext;
    logic signed [XW-1:0]    y_ext;

    assign a_valid_next = in_valid;
    assign prod_full    = magnitude_in * $signed({1'b0, INV_GAIN});
    assign a_prod_next  = prod_full[MW-1:0];
    assign x_ext        = {x_coord[DW-1], x_coord};
    assign y_ext        = {y_coord[DW-1], y_coord};
    assign a_xf_next    = flip_x ? (XW'(0) - x_ext) : x_ext;
    assign a_yf_next    = flip_y ? (XW'(0) - y_ext) : y_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_func_reg <= func;
            a_mag_reg  <= magnitude_in;
            a_ang_reg  <= angle_in;
            a_prod_reg <= a_prod_next;
            a_xf_reg   <= a_xf_next;
            a_yf_reg   <= a_yf_next;
        end
    end

    // Second stage: start vector of the rotation or vectoring run.
    logic                    b_valid_reg;
    cordic_t                 b_data_reg, b_data_next;
    logic signed [XSW-1:0]   x_scaled;
    logic signed [CW-1:0]    x_scaled_ext;
    logic                    fold;
    logic [DW-1:0]           ang_folded;
    logic signed [X8W-1:0]   x8;
    logic signed [X8W-1:0]   y8;
    logic signed [CW-1:0]    x8_ext;
    logic signed [CW-1:0]    y8_ext;
    logic                    x_neg;
    logic [DW:0]             cx;
    logic [DW:0]             cy;

    assign x_scaled     = a_prod_reg[MW-1:16];
    assign x_scaled_ext = {{(CW-XSW){x_scaled[XSW-1]}}, x_scaled};
    // Angles beyond a quarter turn either way start from the opposite side.
    assign fold         = (a_ang_reg > QUARTER) || (a_ang_reg < -QUARTER);
    assign ang_folded   = {~a_ang_reg[DW-1], a_ang_reg[DW-2:0]};
    assign x8           = {a_xf_reg, 8'b0};
    assign y8           = {a_yf_reg, 8'b0};
    assign x8_ext       = {{(CW-X8W){x8[X8W-1]}}, x8};
    assign y8_ext       = {{(CW-X8W){y8[X8W-1]}}, y8};
    assign x_neg        = a_xf_reg[XW-1];
    assign cx = clamp_coord({{(SW-XW){a_xf_reg[XW-1]}}, a_xf_reg}, CW_EFF);
    assign cy = clamp_coord({{(SW-XW){a_yf_reg[XW-1]}}, a_yf_reg}, CW_EFF);

    always_comb
    begin
        b_data_next      = '0;
        b_data_next.func = a_func_reg;
        if (a_func_reg == FUNC_TO_CART)
        begin
            b_data_next.zero  = 1'b0;
            b_data_next.sat   = a_mag_reg[DW-1];
            b_data_next.echo0 = a_mag_reg[DW-1] ? '0 : a_mag_reg;
            b_data_next.echo1 = a_ang_reg;
            b_data_next.x     = fold ? (CW'(0) - x_scaled_ext) : x_scaled_ext;
            b_data_next.y     = '0;
            b_data_next.z     = fold ? {{(ZW-DW){ang_folded[DW-1]}}, ang_folded}
                                     : {{(ZW-DW){a_ang_reg[DW-1]}}, a_ang_reg};
        end
        else
        begin
            b_data_next.zero  = (a_xf_reg == '0) && (a_yf_reg == '0);
            b_data_next.sat   = cx[DW] | cy[DW];
            b_data_next.echo0 = cx[DW-1:0];
            b_data_next.echo1 = cy[DW-1:0];
            // A vector in the left half-plane is turned by pi first.
            b_data_next.x     = x_neg ? (CW'(0) - x8_ext) : x8_ext;
            b_data_next.y     = x_neg ? (CW'(0) - y8_ext) : y8_ext;
            b_data_next.z     = x_neg ? (ZW'(1) << (DW - 1)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

>>> rtl/core/pcc_stage.sv
module pcc_stage #(
    parameter int SHIFT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  pcc_pkg::cordic_t in_data,
    output logic             out_valid,
    output pcc_pkg::cordic_t out_data
);
    import pcc_pkg::*;

    logic                 valid_reg;
    cordic_t              data_reg, data_next;
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [ZW-1:0] atan_v;
    logic                 dir_back;

    assign xi     = in_data.x;
    assign yi     = in_data.y;
    assign zi     = in_data.z;
    assign atan_v = {{(ZW-DW){1'b0}}, ATAN_TAB[SHIFT]};
    // Rotation drives the residual angle to zero, vectoring drives y to zero.
    assign dir_back = (in_data.func == FUNC_TO_POLAR) ? yi[CW-1] : ~zi[ZW-1];

    always_comb
    begin
        data_next = in_data;
        if (dir_back)
        begin
            data_next.x = xi - (yi >>> SHIFT);
            data_next.y = yi + (xi >>> SHIFT);
            data_next.z = zi - atan_v;
        end
        else
        begin
            data_next.x = xi + (yi >>> SHIFT);
            data_next.y = yi - (xi >>> SHIFT);
            data_next.z = zi + atan_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/pcc_post.sv
module pcc_post #(
    parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  pcc_pkg::cordic_t in_data,
    output logic             out_valid,
    output pcc_pkg::res_t    out_data
);
    import pcc_pkg::*;

    localparam int CW_EFF = (COORD_WIDTH < DW) ? COORD_WIDTH : DW;
    localparam int RW     = CW - 16;
    localparam int MX     = PW - 16;
    localparam int MAGW   = PW + 1 - 24;

    // First stage: rounding and clamping of the rotated components, and the
    // two partial products of the gain correction on the vector length.
    logic                 valid_reg;
    logic                 func_reg;
    logic                 zero_reg;
    logic                 sat_reg, sat_next;
    logic [DW-1:0]        echo0_reg;
    logic [DW-1:0]        echo1_reg;
    logic [DW-1:0]        cx_reg;
    logic [DW-1:0]        cy_reg;
    logic [PW-1:0]        pa_reg, pa_next;
    logic [PW-1:0]        pb_reg, pb_next;
    logic [DW-1:0]        z_reg;
    logic signed [CW-1:0] xr_sum;
    logic signed [CW-1:0] yr_sum;
    logic [DW:0]          cx;
    logic [DW:0]          cy;
    logic [MX-1:0]        ux;

    assign xr_sum = in_data.x + (CW'(1) << 15);
    assign yr_sum = in_data.y + (CW'(1) << 15);
    assign cx = clamp_coord({{(SW-RW){xr_sum[CW-1]}}, xr_sum[CW-1:16]}, CW_EFF);
    assign cy = clamp_coord({{(SW-RW){yr_sum[CW-1]}}, yr_sum[CW-1:16]}, CW_EFF);
    // After vectoring x is never negative and stays well inside MX bits.
    assign ux      = in_data.x[MX-1:0];
    assign pa_next = PW'(ux) * PW'(INV_GAIN_HI);
    assign pb_next = PW'(ux) * PW'(INV_GAIN_LO);
    assign sat_next = in_data.sat | ((in_data.func == FUNC_TO_CART) & (cx[DW] | cy[DW]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_reg  <= in_data.func;
            zero_reg  <= in_data.zero;
            sat_reg   <= sat_next;
            echo0_reg <= in_data.echo0;
            echo1_reg <= in_data.echo1;
            cx_reg    <= cx[DW-1:0];
            cy_reg    <= cy[DW-1:0];
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            z_reg     <= in_data.z[DW-1:0];
        end
    end

    // Second half: sum of the partial products, rounding and result select.
    logic [PW:0]     psum;
    logic [MAGW-1:0] mag;
    logic            mag_ovf;

    assign psum    = (PW+1)'(pa_reg) + (PW+1)'(pb_reg[PW-1:16]) + ((PW+1)'(1) << 23);
    assign mag     = psum[PW:24];
    assign mag_ovf = |mag[MAGW-1:DW];

    always_comb
    begin
        out_data = '0;
        if (func_reg == FUNC_TO_CART)
        begin
            out_data.x_out         = cx_reg;
            out_data.y_out         = cy_reg;
            out_data.magnitude_out = echo0_reg;
            out_data.angle_out     = echo1_reg;
            out_data.saturated     = sat_reg;
        end
        else
        begin
            out_data.x_out = echo0_reg;
            out_data.y_out = echo1_reg;
            if (zero_reg)
            begin
                out_data.magnitude_out = '0;
                out_data.angle_out     = '0;
                out_data.saturated     = sat_reg;
            end
            else
            begin
                out_data.magnitude_out = mag_ovf ? '1 : mag[DW-1:0];
                out_data.angle_out     = z_reg;
                out_data.saturated     = sat_reg | mag_ovf;
            end
        end
    end

    assign out_valid = valid_reg;

endmodule

>>> rtl/core/pcc_outbuf.sv
module pcc_outbuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  pcc_pkg::res_t in_data,
    output logic          en,
    output logic          out_valid,
    input  logic          out_ready,
    output pcc_pkg::res_t out_data
);
    import pcc_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic take;

    // The pipeline moves whenever the skid entry is free, so at most one
    // result arrives while the output register is stalled.
    assign en   = ~skid_valid_reg;
    assign take = in_valid & en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                out_data_next  = in_data;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/polar_cartesian_converter.sv
// Polar/cartesian converter, fixed-point CORDIC pipeline.
// Requests arrive on cmd_valid/cmd_ready with func and the operands; func 0
// rotates (magnitude_in, angle_in) into x_out/y_out and echoes the polar pair,
// func 1 optionally negates x_coord/y_coord and returns length and angle.
// Results leave on rsp_valid/rsp_ready; saturated marks a clamped output.
// From acceptance to rsp_valid a request passes two input stages (gain
// multiply, start vector), one register per rotation stage, one
// gain-correction stage and the output register.
// One request is taken per cycle while cmd_ready is high; every rotation
// stage has its own adder set, so the pipeline depth sets latency only.
// Reset clears every valid bit; requests in flight are dropped and
// cmd_ready is high once reset is released.
// When the receiver stalls, the pipeline keeps moving until one more result
// sits in the skid entry behind the output register; only then does
// cmd_ready drop, and it rises again the cycle after the output is taken.
module polar_cartesian_converter #(
    parameter int COORD_WIDTH   = pcc_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = pcc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic                          func,
    input  logic signed [pcc_pkg::DW-1:0] magnitude_in,
    input  logic signed [pcc_pkg::DW-1:0] angle_in,
    input  logic signed [pcc_pkg::DW-1:0] x_coord,
    input  logic signed [pcc_pkg::DW-1:0] y_coord,
    input  logic                          flip_x,
    input  logic                          flip_y,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic signed [pcc_pkg::DW-1:0] x_out,
    output logic signed [pcc_pkg::DW-1:0] y_out,
    output logic [pcc_pkg::DW-1:0]        magnitude_out,
    output logic signed [pcc_pkg::DW-1:0] angle_out,
    output logic                          saturated
);
    import pcc_pkg::*;

    logic    en;
    logic    accept;
    logic    stage_valid [CORDIC_STAGES+1];
    cordic_t stage_data  [CORDIC_STAGES+1];
    logic    post_valid;
    res_t    post_data;
    res_t    rsp_data;

    assign accept = cmd_valid & cmd_ready;

    pcc_pre #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_pre (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (accept),
        .func         (func),
        .magnitude_in (magnitude_in),
        .angle_in     (angle_in),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .out_valid    (stage_valid[0]),
        .out_data     (stage_data[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        pcc_stage #(
            .SHIFT (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    pcc_post #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stage_valid[CORDIC_STAGES]),
        .in_data   (stage_data[CORDIC_STAGES]),
        .out_valid (post_valid),
        .out_data  (post_data)
    );

    pcc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (post_valid),
        .in_data   (post_data),
        .en        (en),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_data  (rsp_data)
    );

    assign cmd_ready     = en;
    assign x_out         = rsp_data.x_out;
    assign y_out         = rsp_data.y_out;
    assign magnitude_out = rsp_data.magnitude_out;
    assign angle_out     = rsp_data.angle_out;
    assign saturated     = rsp_data.saturated;

endmodule

>>> rtl/core/pcc_checker.sv
`include "polar_cartesian_converter_assert.svh"

module pcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic signed [pcc_pkg::DW-1:0] x_out,
    input logic signed [pcc_pkg::DW-1:0] y_out,
    input logic [pcc_pkg::DW-1:0]        magnitude_out,
    input logic signed [pcc_pkg::DW-1:0] angle_out,
    input logic                          saturated
);
    import pcc_pkg::*;

    // Requests are refused only while a finished result waits downstream.
    `PCC_ASSERT_IMP(a_ready_low_has_result, clk, rst_n, !cmd_ready, rsp_valid, "cmd_ready low with no result waiting")

    // The skid entry fills only in a cycle where the output was stalled.
    `PCC_ASSERT_IMP(a_ready_fall_on_stall, clk, rst_n, $fell(cmd_ready), $past(rsp_valid && !rsp_ready), "cmd_ready fell without a stalled result")

    // Taking the output frees the skid entry for the next cycle.
    `PCC_ASSERT_NEXT(a_ready_returns, clk, rst_n, !cmd_ready && rsp_ready, cmd_ready, "cmd_ready stayed low after the output was taken")

    // A stalled result stays put.
    `PCC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(x_out) && $stable(y_out) && $stable(magnitude_out) && $stable(angle_out) && $stable(saturated), "stalled result changed")

endmodule

bind polar_cartesian_converter pcc_checker u_pcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_ready     (cmd_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .x_out         (x_out),
    .y_out         (y_out),
    .magnitude_out (magnitude_out),
    .angle_out     (angle_out),
    .saturated     (saturated)
);
